/* rtl/core/sodg_pkg.sv */
// ----------------------------------------------------------------------------
// sodg_pkg
// Types and constants shared by the send-on-delta gate blocks.
// ----------------------------------------------------------------------------
package sodg_pkg;

  localparam int unsigned SampleW = 17;
  localparam int unsigned GainW   = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned QuoW    = 17;
  localparam int unsigned ProdW   = 50;
  localparam int unsigned KeffW   = ProdW - 16;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned StepW   = 4;

  localparam logic [QuoW-1:0]           Q16One   = 17'h10000;
  localparam logic signed [KeffW-1:0]   KeffCrit = 34'sd8323;
  localparam logic [SampleW-1:0]        ThrReset = 17'd1;

  typedef enum logic [1:0] {
    VERD_ACCEPT  = 2'd0,
    VERD_RETHINK = 2'd1,
    VERD_ABSTAIN = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_DIVL,
    ST_DIVB,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]               lane;
    logic [SampleW-1:0]       sample;
    logic signed [GainW-1:0]  gain;
  } in_t;

  typedef struct packed {
    logic [1:0]          verdict;
    logic                fired;
    logic [QuoW-1:0]     lane_sparsity;
    logic [QuoW-1:0]     bundle_sparsity;
  } out_t;

  typedef struct packed {
    logic [SampleW-1:0]  last;
    logic [1:0]          verdict;
    logic [CountW-1:0]   fired_cnt;
    logic [CountW-1:0]   supp_cnt;
  } lane_rec_t;

  typedef struct packed {
    logic load_in;
    logic calc;
    logic commit;
    logic div_start;
    logic div_bundle;
    logic lane_sp_load;
    logic bund_sp_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* rtl/core/sodg_ram.sv */
// ----------------------------------------------------------------------------
// sodg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sodg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sodg_div.sv */
// ----------------------------------------------------------------------------
// sodg_div
// Radix-2 restoring divider for Q16 fractions n * 65536 / d, saturating at one.
// ----------------------------------------------------------------------------
module sodg_div #(
  parameter int unsigned DW = 33
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DW-1:0]            num_i,
  input  logic [DW-1:0]            den_i,
  output logic                     done_o,
  output logic [sodg_pkg::QuoW-1:0] quo_o
);
  import sodg_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [DW-1:0]     r_q, r_d;
  logic [DW-1:0]     den_q, den_d;
  logic [QuoW-1:0]   q_q, q_d;
  logic [DW:0]       r2;
  logic              bit_s;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    den_d  = den_q;
    q_d    = q_q;
    r2     = {r_q, 1'b0};
    bit_s  = (r2 >= {1'b0, den_q});
    if (start_i) begin
      den_d = den_i;
      cnt_d = '0;
      r_d   = num_i;
      if (den_i == '0) begin
        q_d = '0; done_d = 1'b1; busy_d = 1'b0;
      end else if (num_i >= den_i) begin
        q_d = Q16One; done_d = 1'b1; busy_d = 1'b0;
      end else begin
        q_d = '0; done_d = 1'b0; busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (bit_s) begin
        r_d = DW'(r2 - {1'b0, den_q});
      end else begin
        r_d = r2[DW-1:0];
      end
      q_d   = {1'b0, q_q[QuoW-3:0], bit_s};
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    den_q <= den_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (q_q <= Q16One))
    else $error("quotient above one");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done together");

endmodule

/* rtl/core/sodg_datapath.sv */
// ----------------------------------------------------------------------------
// sodg_datapath
// Lane store, change detect, gain multiply, bundle sums and output register.
// ----------------------------------------------------------------------------
module sodg_datapath #(
  parameter int unsigned LANES = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sodg_pkg::ctrl_cmd_t          cmd_i,
  output sodg_pkg::ctrl_sts_t          sts_o,
  input  sodg_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sodg_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic [sodg_pkg::SampleW-1:0] cfg_data_i
);
  import sodg_pkg::*;

  localparam int unsigned IW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned SW = CountW + ((LANES > 1) ? $clog2(LANES) : 0);
  localparam int unsigned DW = SW + 1;
  localparam int unsigned RecW = $bits(lane_rec_t);

  logic [SampleW-1:0]  thr_q;
  logic [LANES-1:0]    valid_q;
  logic                vld_rd_q;
  in_t                 in_q;
  logic [IW-1:0]       idx_in, idx_q;
  logic [2:0]          lane_m;
  lane_rec_t           rd_rec, cur_q, new_rec;
  logic [RecW-1:0]     rd_raw;
  logic                fire_q, rose_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [17:0]  delta;
  logic signed [17:0]  diff;
  logic [SampleW-1:0]  mag;
  logic [CountW-1:0]   old_total;
  logic [CountW-1:0]   new_total;
  logic [SW-1:0]       fsum_q, ssum_q;
  logic [DW-1:0]       div_num, div_den;
  logic                div_done;
  logic [QuoW-1:0]     div_quo;
  logic [QuoW-1:0]     lane_sp_q, bund_sp_q;
  logic [1:0]          verd_new;
  logic [1:0]          res_verd_q;
  logic                res_fired_q;
  logic                out_valid_q;
  out_t                out_q;
  lane_rec_t           cur_d;

  // fold the lane number into range
  always_comb begin
    lane_m = {1'b0, in_data_i.lane};
    for (int k = 0; k < 3; k++) begin
      if (32'(lane_m) >= LANES) begin
        lane_m = lane_m - 3'(LANES);
      end
    end
  end

  assign idx_in = IW'(lane_m);

  sodg_ram #(.WIDTH(RecW), .DEPTH(LANES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (idx_q),
    .wdata_i (new_rec),
    .raddr_i (idx_in),
    .rdata_o (rd_raw)
  );
  assign rd_rec = lane_rec_t'(rd_raw);

  always_comb begin
    cur_d     = vld_rd_q ? rd_rec : '0;
    diff      = $signed({1'b0, in_q.sample}) - $signed({1'b0, cur_d.last});
    mag       = diff[17] ? SampleW'(-diff) : diff[SampleW-1:0];
    old_total = cur_d.fired_cnt + cur_d.supp_cnt;
    delta     = 18'sh10000 - $signed({1'b0, in_q.sample});
  end

  always_comb begin
    new_rec = cur_q;
    if (fire_q) begin
      if ($signed(prod_q[ProdW-1:16]) < KeffCrit) begin
        verd_new = VERD_ABSTAIN;
      end else if (rose_q) begin
        verd_new = VERD_RETHINK;
      end else begin
        verd_new = VERD_ACCEPT;
      end
      new_rec.last      = in_q.sample;
      new_rec.verdict   = verd_new;
      new_rec.fired_cnt = cur_q.fired_cnt + CountW'(1);
    end else begin
      verd_new         = cur_q.verdict;
      new_rec.supp_cnt = cur_q.supp_cnt + CountW'(1);
    end
    new_total = new_rec.fired_cnt + new_rec.supp_cnt;
    if (cmd_i.div_bundle) begin
      div_num = DW'(ssum_q);
      div_den = DW'(fsum_q) + DW'(ssum_q);
    end else begin
      div_num = DW'(new_rec.supp_cnt);
      div_den = DW'(new_total);
    end
  end

  sodg_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThrReset;
      valid_q     <= '0;
      fsum_q      <= '0;
      ssum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= (cfg_data_i == '0) ? ThrReset : cfg_data_i;
      end
      if (cmd_i.commit) begin
        valid_q[idx_q] <= 1'b1;
        fsum_q <= fsum_q - SW'(cur_q.fired_cnt) + SW'(new_rec.fired_cnt);
        ssum_q <= ssum_q - SW'(cur_q.supp_cnt) + SW'(new_rec.supp_cnt);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q     <= in_data_i;
      idx_q    <= idx_in;
      vld_rd_q <= valid_q[idx_in];
    end
    if (cmd_i.calc) begin
      cur_q  <= cur_d;
      fire_q <= (old_total == '0) || (mag >= thr_q);
      rose_q <= ~diff[17] && (diff != '0);
      prod_q <= delta * in_q.gain;
    end
    if (cmd_i.commit) begin
      res_verd_q  <= verd_new;
      res_fired_q <= fire_q;
    end
    if (cmd_i.lane_sp_load) begin
      lane_sp_q <= div_quo;
    end
    if (cmd_i.bund_sp_load) begin
      bund_sp_q <= div_quo;
    end
    if (cmd_i.out_load) begin
      out_q.verdict         <= res_verd_q;
      out_q.fired           <= res_fired_q;
      out_q.lane_sparsity   <= lane_sp_q;
      out_q.bundle_sparsity <= bund_sp_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_thr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q != '0)
    else $error("threshold zero");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output overwritten");

endmodule

/* rtl/core/sodg_ctrl.sv */
// ----------------------------------------------------------------------------
// sodg_ctrl
// Sequencer: read lane, decide, two divisions, load output.
// ----------------------------------------------------------------------------
module sodg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output sodg_pkg::ctrl_cmd_t cmd_o,
  input  sodg_pkg::ctrl_sts_t sts_i
);
  import sodg_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.commit    = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = ST_DIVL;
      end
      ST_DIVL: begin
        if (sts_i.div_done) begin
          cmd_o.lane_sp_load = 1'b1;
          cmd_o.div_start    = 1'b1;
          cmd_o.div_bundle   = 1'b1;
          state_d = ST_DIVB;
        end
      end
      ST_DIVB: begin
        if (sts_i.div_done) begin
          cmd_o.bund_sp_load = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> (state_q == ST_CALC))
    else $error("transfer taken outside idle");

endmodule

/* rtl/core/send_on_delta_gate_lanes.sv */
// ----------------------------------------------------------------------------
// send_on_delta_gate_lanes
// Send-on-delta verdict gate over LANES lanes with Q16 sparsity reporting.
// ----------------------------------------------------------------------------
// Flow: the transfer is read in, the lane is decided and committed, then the shared
// radix-2 divider runs twice (lane, then bundle), 16 steps each, and the result is
// loaded into the output register once it is free. Items are handled one at a
// time: the next transfer is taken after that load, so output stalls delay it.
// Reset: asynchronous, clears lane valid bits, bundle sums, threshold to one.
module send_on_delta_gate_lanes #(
  parameter int unsigned LANES = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sodg_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sodg_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic [sodg_pkg::SampleW-1:0] cfg_data_i
);
  import sodg_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sodg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sodg_datapath #(.LANES(LANES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
